>>> design/twoc_pkg.sv
// package: shared constants and the group row type of tree_weighted_order_cost
`timescale 1ns / 1ps
package twoc_pkg;
	localparam int MAX_NODES = 1024;
	localparam int SLOTS     = MAX_NODES + 1;
	localparam int NODE_W    = $clog2(SLOTS);
	localparam int WGT_W     = 31;
	localparam int SUM_W     = 42;
	localparam int PROD_W    = SUM_W + NODE_W;
	localparam int COST_W    = 54;
	localparam int OUT_W     = 53;

	typedef struct packed {
		logic [NODE_W-1:0] leader;
		logic [NODE_W-1:0] top;
		logic [NODE_W-1:0] size;
		logic [SUM_W-1:0]  sum;
		logic [COST_W-1:0] cost;
	} row_t;
endpackage

>>> design/tree_weighted_order_cost.sv
// top level: greedy tree ordering cost with union-find groups in block memories
//
// input stream (s_axis): one word per node 1..n, in node order
//   tdata holds parent_index and weight, tlast marks the final node of a set
//   a load word is taken every cycle while loading; words beyond 1024 nodes
//   are dropped and flag the set as bad
// output stream (m_axis): one word per set, after the tlast word
//   tdata holds total_cost, tuser holds not_a_tree
// after tlast the block stops taking words and works on the set:
//   reachability walk over the parent memory: each node walks parent links
//   until it hits a lower index, at most n steps
//   merge rounds: each round scans all n+1 group rows, then a find walk over
//   leader links and two row writes, over n+1 rounds
// a set flagged at load skips the walk; one flagged by the walk ends there
// the result waits in an output register while the receiver stalls; a new
// set may load meanwhile, and its result holds the input off until it leaves
// reset clears the node count, the flags and the output; rows are rewritten
module tree_weighted_order_cost (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [47:0] s_axis_tdata,   // parent_index[10:0], weight[41:11], zero fill
	input  logic        s_axis_tlast,
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [55:0] m_axis_tdata,   // total_cost[52:0], zero fill
	output logic [0:0]  m_axis_tuser    // not_a_tree
);
	localparam int NW = twoc_pkg::NODE_W;

	localparam logic [3:0] ST_LOAD     = 4'd0;
	localparam logic [3:0] ST_CK_ISSUE = 4'd1;
	localparam logic [3:0] ST_CK_EVAL  = 4'd2;
	localparam logic [3:0] ST_ROW0     = 4'd3;
	localparam logic [3:0] ST_SCAN     = 4'd4;
	localparam logic [3:0] ST_SCAN_END = 4'd5;
	localparam logic [3:0] ST_PICK     = 4'd6;
	localparam logic [3:0] ST_PAR      = 4'd7;
	localparam logic [3:0] ST_FIND_A   = 4'd8;
	localparam logic [3:0] ST_FIND_B   = 4'd9;
	localparam logic [3:0] ST_MUL      = 4'd10;
	localparam logic [3:0] ST_W1       = 4'd11;
	localparam logic [3:0] ST_W2       = 4'd12;
	localparam logic [3:0] ST_ROOT     = 4'd13;
	localparam logic [3:0] ST_DONE     = 4'd14;

	// memories
	logic [NW-1:0]     par_mem [twoc_pkg::SLOTS];
	twoc_pkg::row_t    grp_mem [twoc_pkg::SLOTS];
	logic [NW-1:0]     par_rd_q;
	twoc_pkg::row_t    row_rd_q;
	logic [NW-1:0]     par_ra, par_wa, grp_ra, grp_wa;
	logic              par_we, grp_we;
	twoc_pkg::row_t    grp_wd;

	// control
	logic [3:0]        state_q;
	logic [NW-1:0]     node_cnt_q, n_q, i_q, steps_q, j_q, f_q;
	logic              ovf_q, root_q;
	logic              scan_v_s1;
	logic [NW-1:0]     sidx_s1;

	// best candidate of the current scan
	logic              best_v_q;
	logic [NW-1:0]     best_idx_q, best_size_q, best_top_q;
	logic [twoc_pkg::SUM_W-1:0]  best_sum_q;
	logic [twoc_pkg::COST_W-1:0] best_cost_q;

	// parent side group
	logic [NW-1:0]     ap_idx_q, ap_size_q, ap_top_q;
	logic [twoc_pkg::SUM_W-1:0]  ap_sum_q;
	logic [twoc_pkg::COST_W-1:0] ap_cost_q;
	logic [twoc_pkg::PROD_W-1:0] offset_q;
	logic [NW-1:0]     win_q;

	// result of the set in work
	logic              res_bad_q;
	logic [twoc_pkg::OUT_W-1:0]  res_cost_q;

	// result word held for the receiver
	logic              out_bad_q;
	logic [twoc_pkg::OUT_W-1:0]  out_cost_q;

	logic              s_acc, store_ok, cur_low, cand, better, ap_smaller;
	logic [NW-1:0]     k_new;
	logic [twoc_pkg::PROD_W-1:0] lhs, rhs;

	assign s_axis_tready = (state_q == ST_LOAD);
	assign s_acc    = s_axis_tvalid && s_axis_tready;
	assign store_ok = (node_cnt_q < NW'(twoc_pkg::MAX_NODES));
	assign k_new    = node_cnt_q + NW'(1);
	assign cur_low  = (par_rd_q < i_q);

	// scan compare: average of the row below the best one, by cross products
	assign cand   = scan_v_s1 && (row_rd_q.leader == sidx_s1) && (row_rd_q.top != '0);
	assign lhs    = twoc_pkg::PROD_W'(row_rd_q.sum) * twoc_pkg::PROD_W'(best_size_q);
	assign rhs    = twoc_pkg::PROD_W'(best_sum_q) * twoc_pkg::PROD_W'(row_rd_q.size);
	assign better = !best_v_q || (lhs < rhs);
	assign ap_smaller = (ap_size_q < best_size_q);

	// memory address and write muxing
	always_comb begin
		par_ra = i_q;
		case (state_q)
			ST_CK_EVAL: par_ra = par_rd_q;
			ST_PAR:     par_ra = best_top_q;
			default:    par_ra = i_q;
		endcase
		grp_ra = j_q;
		case (state_q)
			ST_FIND_A: grp_ra = par_rd_q;
			ST_FIND_B: grp_ra = row_rd_q.leader;
			ST_ROOT:   grp_ra = '0;
			default:   grp_ra = j_q;
		endcase
		par_we = s_acc && store_ok;
		par_wa = k_new;
		grp_we = 1'b0;
		grp_wa = k_new;
		grp_wd = '{leader: k_new, top: k_new, size: NW'(1),
			sum: twoc_pkg::SUM_W'(s_axis_tdata[41:11]), cost: '0};
		case (state_q)
			ST_LOAD: grp_we = s_acc && store_ok;
			ST_ROW0: begin
				grp_we = 1'b1;
				grp_wa = '0;
				grp_wd = '{leader: '0, top: '0, size: NW'(1), sum: '0, cost: '0};
			end
			ST_W1, ST_W2: begin
				grp_we = 1'b1;
				grp_wa = (state_q == ST_W1) ? win_q :
					((win_q == ap_idx_q) ? best_idx_q : ap_idx_q);
				grp_wd.leader = win_q;
				grp_wd.top    = ap_top_q;
				grp_wd.size   = ap_size_q + best_size_q;
				grp_wd.sum    = ap_sum_q + best_sum_q;
				grp_wd.cost   = ap_cost_q + best_cost_q + twoc_pkg::COST_W'(offset_q);
			end
			default: grp_we = 1'b0;
		endcase
	end

	always_ff @(posedge clk) begin
		if (par_we) par_mem[par_wa] <= s_axis_tdata[10:0];
		par_rd_q <= par_mem[par_ra];
	end

	always_ff @(posedge clk) begin
		if (grp_we) grp_mem[grp_wa] <= grp_wd;
		row_rd_q <= grp_mem[grp_ra];
	end

	// scan pipeline and data registers
	always_ff @(posedge clk) begin
		if (cand && better) begin
			best_idx_q  <= sidx_s1;
			best_size_q <= row_rd_q.size;
			best_sum_q  <= row_rd_q.sum;
			best_cost_q <= row_rd_q.cost;
			best_top_q  <= row_rd_q.top;
		end
		if (state_q == ST_FIND_B && row_rd_q.leader == f_q) begin
			ap_idx_q  <= f_q;
			ap_size_q <= row_rd_q.size;
			ap_sum_q  <= row_rd_q.sum;
			ap_cost_q <= row_rd_q.cost;
			ap_top_q  <= row_rd_q.top;
		end
		if (state_q == ST_MUL) begin
			offset_q <= twoc_pkg::PROD_W'(best_sum_q) * twoc_pkg::PROD_W'(ap_size_q);
			win_q    <= ap_smaller ? best_idx_q : ap_idx_q;
		end
		sidx_s1 <= j_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_LOAD;
			node_cnt_q    <= '0;
			n_q           <= '0;
			i_q           <= '0;
			steps_q       <= '0;
			j_q           <= '0;
			f_q           <= '0;
			ovf_q         <= 1'b0;
			root_q        <= 1'b0;
			scan_v_s1     <= 1'b0;
			best_v_q      <= 1'b0;
			res_bad_q     <= 1'b0;
			res_cost_q    <= '0;
			out_bad_q     <= 1'b0;
			out_cost_q    <= '0;
			m_axis_tvalid <= 1'b0;
		end else begin
			if (state_q == ST_DONE && (!m_axis_tvalid || m_axis_tready))
				m_axis_tvalid <= 1'b1;
			else if (m_axis_tready)
				m_axis_tvalid <= 1'b0;
			scan_v_s1 <= (state_q == ST_SCAN);
			if (cand && better) best_v_q <= 1'b1;
			case (state_q)
				ST_LOAD: begin
					if (s_acc) begin
						if (s_axis_tlast) begin
							n_q        <= store_ok ? k_new : node_cnt_q;
							node_cnt_q <= '0;
							ovf_q      <= 1'b0;
							i_q        <= NW'(1);
							res_cost_q <= '0;
							if (ovf_q || !store_ok) begin
								res_bad_q <= 1'b1;
								state_q   <= ST_DONE;
							end else begin
								state_q <= ST_CK_ISSUE;
							end
						end else if (store_ok) begin
							node_cnt_q <= k_new;
						end else begin
							ovf_q <= 1'b1;
						end
					end
				end
				ST_CK_ISSUE: begin
					steps_q <= '0;
					state_q <= ST_CK_EVAL;
				end
				ST_CK_EVAL: begin
					// lower indexes are already known to reach the root
					if (cur_low) begin
						if (i_q == n_q) begin
							state_q <= ST_ROW0;
						end else begin
							i_q     <= i_q + NW'(1);
							state_q <= ST_CK_ISSUE;
						end
					end else if (par_rd_q > n_q || steps_q == n_q) begin
						res_bad_q <= 1'b1;
						state_q   <= ST_DONE;
					end else begin
						steps_q <= steps_q + NW'(1);
					end
				end
				ST_ROW0: begin
					j_q      <= '0;
					best_v_q <= 1'b0;
					state_q  <= ST_SCAN;
				end
				ST_SCAN: begin
					if (j_q == n_q) state_q <= ST_SCAN_END;
					else j_q <= j_q + NW'(1);
				end
				ST_SCAN_END: state_q <= ST_PICK;
				ST_PICK: begin
					root_q  <= !best_v_q;
					state_q <= best_v_q ? ST_PAR : ST_ROOT;
				end
				ST_PAR: state_q <= ST_FIND_A;
				ST_FIND_A: begin
					f_q     <= par_rd_q;
					state_q <= ST_FIND_B;
				end
				ST_FIND_B: begin
					if (row_rd_q.leader == f_q) begin
						if (root_q) begin
							res_bad_q  <= 1'b0;
							res_cost_q <= row_rd_q.cost[twoc_pkg::OUT_W-1:0];
							state_q    <= ST_DONE;
						end else begin
							state_q <= ST_MUL;
						end
					end else begin
						f_q <= row_rd_q.leader;
					end
				end
				ST_MUL: state_q <= ST_W1;
				ST_W1:  state_q <= ST_W2;
				ST_W2: begin
					j_q      <= '0;
					best_v_q <= 1'b0;
					state_q  <= ST_SCAN;
				end
				ST_ROOT: begin
					f_q     <= '0;
					state_q <= ST_FIND_B;
				end
				ST_DONE: begin
					if (!m_axis_tvalid || m_axis_tready) begin
						out_bad_q  <= res_bad_q;
						out_cost_q <= res_cost_q;
						state_q    <= ST_LOAD;
					end
				end
				default: state_q <= ST_LOAD;
			endcase
		end
	end

	assign m_axis_tdata = {3'b000, out_cost_q};
	assign m_axis_tuser = out_bad_q;

	// a bad set never carries a cost
	a_bad_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser[0] |-> m_axis_tdata == '0)
		else $error("bad set with nonzero cost");

	// the find walk stays inside the loaded nodes
	a_find_range: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_FIND_B |-> f_q <= n_q)
		else $error("find walk left the node range");

	// a merged group is larger than either part
	a_merge_size: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_W1 |-> grp_wd.size > ap_size_q && grp_wd.size > best_size_q)
		else $error("merge size did not grow");

	// a merge round only starts from a found candidate outside the root group
	a_pick: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_PAR |-> best_v_q && best_top_q != '0)
		else $error("merge without a candidate");
endmodule
